/* rtl/mi4_pkg.sv */
// shared types, state codes and index tables for the 4x4 matrix inverse
`default_nettype none

package mi4_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int NUM_ENTRIES = 16;
    localparam int NUM_PAIRS   = 24;
    localparam int HALF_PAIRS  = 12;
    localparam int NUM_TERMS   = 6;

    typedef struct packed {
        logic [3:0]                   entry_index;
        logic signed [DATA_WIDTH-1:0] entry_value;
        logic                         last_entry;
    } entry_t;

    typedef struct packed {
        logic [3:0]                   result_index;
        logic signed [DATA_WIDTH-1:0] result_value;
        logic                         singular;
        logic                         saturated;
        logic                         last_result;
    } result_t;

    // request to the shared multiplier: wide selects the final-scaling mode
    typedef struct packed {
        logic start;
        logic wide;
    } mul_ctl_t;

    typedef struct packed {
        logic done;
        logic sat;
    } unit_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_A,
        ST_LOAD_B,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_PAIR,
        PH_TERM,
        PH_DET,
        PH_OUT
    } phase_t;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_RUN,
        MS_SIGN,
        MS_FIN
    } mul_state_t;

    // pair products over the transposed matrix, indexes into the transpose
    localparam logic [3:0] PAIR_A [NUM_PAIRS] = '{
        4'd10, 4'd11, 4'd9,  4'd11, 4'd9,  4'd10, 4'd8, 4'd11, 4'd8, 4'd10, 4'd8, 4'd9,
        4'd2,  4'd3,  4'd1,  4'd3,  4'd1,  4'd2,  4'd0, 4'd3,  4'd0, 4'd2,  4'd0, 4'd1
    };
    localparam logic [3:0] PAIR_B [NUM_PAIRS] = '{
        4'd15, 4'd14, 4'd15, 4'd13, 4'd14, 4'd13, 4'd15, 4'd12, 4'd14, 4'd12, 4'd13, 4'd12,
        4'd7,  4'd6,  4'd7,  4'd5,  4'd6,  4'd5,  4'd7,  4'd4,  4'd6,  4'd4,  4'd5,  4'd4
    };

    // per cofactor: pair index within its half and transpose entry, three added then three
    // subtracted
    localparam logic [3:0] COF_PAIR [NUM_ENTRIES][NUM_TERMS] = '{
        '{4'd0, 4'd3, 4'd4, 4'd1, 4'd2, 4'd5},
        '{4'd1, 4'd6, 4'd9, 4'd0, 4'd7, 4'd8},
        '{4'd2, 4'd7, 4'd10, 4'd3, 4'd6, 4'd11},
        '{4'd5, 4'd8, 4'd11, 4'd4, 4'd9, 4'd10},
        '{4'd1, 4'd2, 4'd5, 4'd0, 4'd3, 4'd4},
        '{4'd0, 4'd7, 4'd8, 4'd1, 4'd6, 4'd9},
        '{4'd3, 4'd6, 4'd11, 4'd2, 4'd7, 4'd10},
        '{4'd4, 4'd9, 4'd10, 4'd5, 4'd8, 4'd11},
        '{4'd0, 4'd3, 4'd4, 4'd1, 4'd2, 4'd5},
        '{4'd1, 4'd6, 4'd9, 4'd0, 4'd7, 4'd8},
        '{4'd2, 4'd7, 4'd10, 4'd3, 4'd6, 4'd11},
        '{4'd5, 4'd8, 4'd11, 4'd4, 4'd9, 4'd10},
        '{4'd2, 4'd5, 4'd1, 4'd4, 4'd0, 4'd3},
        '{4'd8, 4'd0, 4'd7, 4'd6, 4'd9, 4'd1},
        '{4'd6, 4'd11, 4'd3, 4'd10, 4'd2, 4'd7},
        '{4'd10, 4'd4, 4'd9, 4'd8, 4'd11, 4'd5}
    };
    localparam logic [3:0] COF_ENTRY [NUM_ENTRIES][NUM_TERMS] = '{
        '{4'd5, 4'd6, 4'd7, 4'd5, 4'd6, 4'd7},
        '{4'd4, 4'd6, 4'd7, 4'd4, 4'd6, 4'd7},
        '{4'd4, 4'd5, 4'd7, 4'd4, 4'd5, 4'd7},
        '{4'd4, 4'd5, 4'd6, 4'd4, 4'd5, 4'd6},
        '{4'd1, 4'd2, 4'd3, 4'd1, 4'd2, 4'd3},
        '{4'd0, 4'd2, 4'd3, 4'd0, 4'd2, 4'd3},
        '{4'd0, 4'd1, 4'd3, 4'd0, 4'd1, 4'd3},
        '{4'd0, 4'd1, 4'd2, 4'd0, 4'd1, 4'd2},
        '{4'd13, 4'd14, 4'd15, 4'd13, 4'd14, 4'd15},
        '{4'd12, 4'd14, 4'd15, 4'd12, 4'd14, 4'd15},
        '{4'd12, 4'd13, 4'd15, 4'd12, 4'd13, 4'd15},
        '{4'd12, 4'd13, 4'd14, 4'd12, 4'd13, 4'd14},
        '{4'd10, 4'd11, 4'd9, 4'd11, 4'd9, 4'd10},
        '{4'd11, 4'd8, 4'd10, 4'd10, 4'd11, 4'd8},
        '{4'd9, 4'd11, 4'd8, 4'd11, 4'd8, 4'd9},
        '{4'd10, 4'd8, 4'd9, 4'd9, 4'd10, 4'd8}
    };

endpackage

`default_nettype wire

/* rtl/matrix_inverse_4x4_unit.sv */
// 4x4 matrix inverse by cofactors: entry store, sequencer and result register
//
//  channel | ports                      | payload                  | role
//  s_      | s_valid s_ready s_data     | mi4_pkg::entry_t         | matrix entries
//  m_      | m_valid m_ready m_data     | mi4_pkg::result_t        | inverse entries
//
// an entry without last_entry is only stored. the last one is stored and starts a run of
// 140 multiplies (124 for a singular matrix) on one shared multiplier (each: two operand loads,
// start, chunked product, sign, shift and clamp) and, for a nonzero determinant, a restoring
// divide for the reciprocal; s_ready is low meanwhile.
// each result waits in the output register until taken. synchronous reset clears
// control only; the entry store holds whatever was last written.
`default_nettype none

module matrix_inverse_4x4_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire mi4_pkg::entry_t  s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output mi4_pkg::result_t      m_data
);

    localparam int DW = mi4_pkg::DATA_WIDTH;
    localparam int CW = DW + FRACTION_BITS;
    localparam int AW = CW + 3;
    localparam logic [AW-1:0] MAX_A = (AW'(1) << (CW - 1)) - AW'(1);
    localparam logic [AW-1:0] MIN_A = ~MAX_A;

    mi4_pkg::state_t  state_reg, state_next;
    mi4_pkg::phase_t  phase_reg;
    logic [4:0]       cnt_reg;
    logic [3:0]       row_reg;
    logic [2:0]       term_reg;

    logic signed [DW-1:0] src_reg  [mi4_pkg::NUM_ENTRIES];
    logic signed [CW-1:0] pr_reg   [mi4_pkg::NUM_PAIRS];
    logic                 psat_reg [mi4_pkg::NUM_PAIRS];
    logic signed [CW-1:0] cof_reg  [mi4_pkg::NUM_ENTRIES];
    logic                 csat_reg [mi4_pkg::NUM_ENTRIES];
    logic signed [CW-1:0] recip_reg;
    logic signed [CW-1:0] det_reg;
    logic                 dsat_reg;
    logic                 fsat_reg;
    logic                 singular_reg;
    logic [AW-1:0]        acc_reg;
    logic signed [CW-1:0] a_reg;
    logic signed [CW-1:0] b_reg;
    mi4_pkg::result_t     out_reg;

    mi4_pkg::mul_ctl_t    mul_ctl;
    mi4_pkg::unit_stat_t  mul_stat;
    logic signed [CW-1:0] mul_res;
    logic                 div_start;
    mi4_pkg::unit_stat_t  div_stat;
    logic [CW-2:0]        div_q;

    logic                 s_fire;
    logic [3:0]           t_idx;
    logic signed [CW-1:0] src_ext;
    logic [4:0]           pr_addr;
    logic [AW-1:0]        res_ext;
    logic [AW-1:0]        acc_sum;
    logic                 acc_hi;
    logic                 acc_lo;
    logic [CW-1:0]        acc_cl;
    logic                 fsat_new;
    logic [CW-1:0]        det_mag;

    assign s_fire = s_valid && s_ready;

    // operand address into the transpose, mapped back to the row-major store
    always_comb begin
        t_idx = '0;
        if (state_reg == mi4_pkg::ST_LOAD_A) begin
            if (phase_reg == mi4_pkg::PH_PAIR) begin
                t_idx = mi4_pkg::PAIR_A[cnt_reg];
            end else begin
                t_idx = cnt_reg[3:0];
            end
        end else begin
            if (phase_reg == mi4_pkg::PH_PAIR) begin
                t_idx = mi4_pkg::PAIR_B[cnt_reg];
            end else begin
                t_idx = mi4_pkg::COF_ENTRY[row_reg][term_reg];
            end
        end
    end

    assign src_ext = CW'(src_reg[{t_idx[1:0], t_idx[3:2]}]);
    assign pr_addr = 5'(mi4_pkg::COF_PAIR[row_reg][term_reg])
                   + (row_reg[3] ? 5'(mi4_pkg::HALF_PAIRS) : 5'd0);

    assign res_ext = AW'(mul_res);
    assign acc_sum = (phase_reg == mi4_pkg::PH_TERM && term_reg >= 3'd3)
                   ? acc_reg - res_ext : acc_reg + res_ext;
    assign acc_hi  = $signed(acc_sum) > $signed(MAX_A);
    assign acc_lo  = $signed(acc_sum) < $signed(MIN_A);
    assign acc_cl  = acc_hi ? MAX_A[CW-1:0] : (acc_lo ? MIN_A[CW-1:0] : acc_sum[CW-1:0]);
    assign fsat_new = fsat_reg | mul_stat.sat | psat_reg[pr_addr];
    assign det_mag  = det_reg[CW-1] ? CW'(~det_reg + 1'b1) : det_reg;

    mi4_mul #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (mul_ctl),
        .op_a   (a_reg),
        .op_b   (b_reg),
        .stat   (mul_stat),
        .result (mul_res)
    );

    mi4_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (det_mag),
        .stat    (div_stat),
        .quotient(div_q)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mi4_pkg::ST_IDLE: begin
                if (s_fire && s_data.last_entry) begin
                    state_next = mi4_pkg::ST_LOAD_A;
                end
            end
            mi4_pkg::ST_LOAD_A: begin
                if (phase_reg == mi4_pkg::PH_OUT && singular_reg) begin
                    state_next = mi4_pkg::ST_EMIT;
                end else begin
                    state_next = mi4_pkg::ST_LOAD_B;
                end
            end
            mi4_pkg::ST_LOAD_B: state_next = mi4_pkg::ST_MUL_GO;
            mi4_pkg::ST_MUL_GO: state_next = mi4_pkg::ST_MUL_WAIT;
            mi4_pkg::ST_MUL_WAIT: begin
                if (mul_stat.done) begin
                    if (phase_reg == mi4_pkg::PH_OUT) begin
                        state_next = mi4_pkg::ST_EMIT;
                    end else if (phase_reg == mi4_pkg::PH_DET && cnt_reg == 5'd3) begin
                        state_next = (acc_cl == '0) ? mi4_pkg::ST_LOAD_A : mi4_pkg::ST_DIV_GO;
                    end else begin
                        state_next = mi4_pkg::ST_LOAD_A;
                    end
                end
            end
            mi4_pkg::ST_DIV_GO: state_next = mi4_pkg::ST_DIV_WAIT;
            mi4_pkg::ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    state_next = mi4_pkg::ST_LOAD_A;
                end
            end
            mi4_pkg::ST_EMIT: begin
                if (m_ready) begin
                    state_next = (cnt_reg == 5'd15) ? mi4_pkg::ST_IDLE : mi4_pkg::ST_LOAD_A;
                end
            end
            default: state_next = mi4_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == mi4_pkg::ST_IDLE);
        m_valid       = (state_reg == mi4_pkg::ST_EMIT);
        mul_ctl.start = (state_reg == mi4_pkg::ST_MUL_GO);
        mul_ctl.wide  = (phase_reg == mi4_pkg::PH_OUT);
        div_start     = (state_reg == mi4_pkg::ST_DIV_GO);
        m_data        = out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mi4_pkg::ST_IDLE;
            phase_reg <= mi4_pkg::PH_PAIR;
            cnt_reg   <= '0;
            row_reg   <= '0;
            term_reg  <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                mi4_pkg::ST_IDLE: begin
                    if (s_fire && s_data.last_entry) begin
                        phase_reg <= mi4_pkg::PH_PAIR;
                        cnt_reg   <= '0;
                    end
                end
                mi4_pkg::ST_MUL_WAIT: begin
                    if (mul_stat.done) begin
                        case (phase_reg)
                            mi4_pkg::PH_PAIR: begin
                                if (cnt_reg == 5'(mi4_pkg::NUM_PAIRS - 1)) begin
                                    phase_reg <= mi4_pkg::PH_TERM;
                                    row_reg   <= '0;
                                    term_reg  <= '0;
                                end else begin
                                    cnt_reg <= cnt_reg + 1'b1;
                                end
                            end
                            mi4_pkg::PH_TERM: begin
                                if (term_reg == 3'(mi4_pkg::NUM_TERMS - 1)) begin
                                    term_reg <= '0;
                                    if (row_reg == 4'd15) begin
                                        phase_reg <= mi4_pkg::PH_DET;
                                        cnt_reg   <= '0;
                                    end else begin
                                        row_reg <= row_reg + 1'b1;
                                    end
                                end else begin
                                    term_reg <= term_reg + 1'b1;
                                end
                            end
                            mi4_pkg::PH_DET: begin
                                if (cnt_reg == 5'd3) begin
                                    if (acc_cl == '0) begin
                                        phase_reg <= mi4_pkg::PH_OUT;
                                        cnt_reg   <= '0;
                                    end
                                end else begin
                                    cnt_reg <= cnt_reg + 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                mi4_pkg::ST_DIV_WAIT: begin
                    if (div_stat.done) begin
                        phase_reg <= mi4_pkg::PH_OUT;
                        cnt_reg   <= '0;
                    end
                end
                mi4_pkg::ST_EMIT: begin
                    if (m_ready) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            src_reg[s_data.entry_index] <= s_data.entry_value;
        end
        case (state_reg)
            mi4_pkg::ST_IDLE: begin
                acc_reg  <= '0;
                fsat_reg <= 1'b0;
                dsat_reg <= 1'b0;
            end
            mi4_pkg::ST_LOAD_A: begin
                case (phase_reg)
                    mi4_pkg::PH_TERM: a_reg <= pr_reg[pr_addr];
                    mi4_pkg::PH_OUT:  a_reg <= cof_reg[cnt_reg[3:0]];
                    default:          a_reg <= src_ext;
                endcase
                if (phase_reg == mi4_pkg::PH_OUT && singular_reg) begin
                    out_reg.result_index <= cnt_reg[3:0];
                    out_reg.result_value <= '0;
                    out_reg.singular     <= 1'b1;
                    out_reg.saturated    <= 1'b0;
                    out_reg.last_result  <= (cnt_reg == 5'd15);
                end
            end
            mi4_pkg::ST_LOAD_B: begin
                case (phase_reg)
                    mi4_pkg::PH_DET: b_reg <= cof_reg[cnt_reg[3:0]];
                    mi4_pkg::PH_OUT: b_reg <= recip_reg;
                    default:         b_reg <= src_ext;
                endcase
            end
            mi4_pkg::ST_MUL_WAIT: begin
                if (mul_stat.done) begin
                    case (phase_reg)
                        mi4_pkg::PH_PAIR: begin
                            pr_reg[cnt_reg]   <= mul_res;
                            psat_reg[cnt_reg] <= mul_stat.sat;
                        end
                        mi4_pkg::PH_TERM: begin
                            if (term_reg == 3'(mi4_pkg::NUM_TERMS - 1)) begin
                                cof_reg[row_reg]  <= acc_cl;
                                csat_reg[row_reg] <= fsat_new | acc_hi | acc_lo;
                                acc_reg           <= '0;
                                fsat_reg          <= 1'b0;
                            end else begin
                                acc_reg  <= acc_sum;
                                fsat_reg <= fsat_new;
                            end
                        end
                        mi4_pkg::PH_DET: begin
                            if (cnt_reg == 5'd3) begin
                                det_reg      <= acc_cl;
                                singular_reg <= (acc_cl == '0);
                                dsat_reg     <= dsat_reg | mul_stat.sat | acc_hi | acc_lo;
                            end else begin
                                acc_reg  <= acc_sum;
                                dsat_reg <= dsat_reg | mul_stat.sat;
                            end
                        end
                        default: begin
                            out_reg.result_index <= cnt_reg[3:0];
                            out_reg.result_value <= mul_res[DW-1:0];
                            out_reg.singular     <= 1'b0;
                            out_reg.saturated    <= mul_stat.sat | csat_reg[cnt_reg[3:0]]
                                                  | dsat_reg;
                            out_reg.last_result  <= (cnt_reg == 5'd15);
                        end
                    endcase
                end
            end
            mi4_pkg::ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    recip_reg <= det_reg[CW-1] ? CW'(~{1'b0, div_q} + 1'b1) : {1'b0, div_q};
                    dsat_reg  <= dsat_reg | div_stat.sat;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/mi4_mul.sv */
// shared signed multiplier: chunked partial products, arithmetic shift, saturation
`default_nettype none

module mi4_mul #(
    parameter int FRACTION_BITS = 16,
    localparam int CW = mi4_pkg::DATA_WIDTH + FRACTION_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire mi4_pkg::mul_ctl_t    ctl,
    input  wire logic signed [CW-1:0] op_a,
    input  wire logic signed [CW-1:0] op_b,
    output mi4_pkg::unit_stat_t       stat,
    output logic signed [CW-1:0]      result
);

    localparam int DW    = mi4_pkg::DATA_WIDTH;
    localparam int PW    = 2 * CW;
    localparam int CHUNK = 16;
    localparam int NCH   = (CW + CHUNK - 1) / CHUNK;
    localparam int BW    = NCH * CHUNK;
    localparam int SW    = $clog2(NCH + 1);
    localparam logic [PW-1:0] MAX_C = (PW'(1) << (CW - 1)) - PW'(1);
    localparam logic [PW-1:0] MIN_C = ~MAX_C;
    localparam logic [PW-1:0] MAX_D = (PW'(1) << (DW - 1)) - PW'(1);
    localparam logic [PW-1:0] MIN_D = ~MAX_D;

    mi4_pkg::mul_state_t state_reg, state_next;
    logic                neg_reg;
    logic                wide_reg;
    logic [CW-1:0]       ma_reg;
    logic [BW-1:0]       mb_reg;
    logic [PW-1:0]       acc_reg;
    logic [SW-1:0]       step_reg;

    logic [CW-1:0]        a_mag;
    logic [CW-1:0]        b_mag;
    logic [CW+CHUNK-1:0]  part;
    logic signed [PW-1:0] shifted;
    logic [PW-1:0]        max_sel;
    logic [PW-1:0]        min_sel;
    logic                 over_hi;
    logic                 over_lo;
    logic [PW-1:0]        clamped;

    assign a_mag = op_a[CW-1] ? CW'(~op_a + 1'b1) : op_a;
    assign b_mag = op_b[CW-1] ? CW'(~op_b + 1'b1) : op_b;
    assign part  = (CW + CHUNK)'(ma_reg) * (CW + CHUNK)'(mb_reg[BW-1 -: CHUNK]);

    // floor shift of the signed product, then clamp to the selected width
    assign shifted = wide_reg ? ($signed(acc_reg) >>> (2 * FRACTION_BITS))
                              : ($signed(acc_reg) >>> FRACTION_BITS);
    assign max_sel = wide_reg ? MAX_D : MAX_C;
    assign min_sel = wide_reg ? MIN_D : MIN_C;
    assign over_hi = shifted > $signed(max_sel);
    assign over_lo = shifted < $signed(min_sel);
    assign clamped = over_hi ? max_sel : (over_lo ? min_sel : shifted);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mi4_pkg::MS_IDLE: begin
                if (ctl.start) begin
                    state_next = mi4_pkg::MS_RUN;
                end
            end
            mi4_pkg::MS_RUN: begin
                if (step_reg == SW'(NCH - 1)) begin
                    state_next = mi4_pkg::MS_SIGN;
                end
            end
            mi4_pkg::MS_SIGN: state_next = mi4_pkg::MS_FIN;
            mi4_pkg::MS_FIN:  state_next = mi4_pkg::MS_IDLE;
            default:          state_next = mi4_pkg::MS_IDLE;
        endcase
    end

    always_comb begin
        stat.done = (state_reg == mi4_pkg::MS_FIN);
        stat.sat  = over_hi | over_lo;
        result    = clamped[CW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mi4_pkg::MS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            mi4_pkg::MS_IDLE: begin
                if (ctl.start) begin
                    neg_reg  <= op_a[CW-1] ^ op_b[CW-1];
                    wide_reg <= ctl.wide;
                    ma_reg   <= a_mag;
                    mb_reg   <= BW'(b_mag);
                    acc_reg  <= '0;
                    step_reg <= '0;
                end
            end
            mi4_pkg::MS_RUN: begin
                acc_reg  <= (acc_reg << CHUNK) + PW'(part);
                mb_reg   <= mb_reg << CHUNK;
                step_reg <= step_reg + 1'b1;
            end
            mi4_pkg::MS_SIGN: begin
                if (neg_reg) begin
                    acc_reg <= ~acc_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/mi4_div.sv */
// restoring divider for the determinant reciprocal, one quotient bit per cycle
`default_nettype none

module mi4_div #(
    parameter int FRACTION_BITS = 16,
    localparam int CW = mi4_pkg::DATA_WIDTH + FRACTION_BITS
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [CW-1:0] divisor,
    output mi4_pkg::unit_stat_t stat,
    output logic [CW-2:0]      quotient
);

    localparam int QW = 3 * FRACTION_BITS + 1;
    localparam int WW = (QW > CW) ? QW : CW;
    localparam int NW = $clog2(QW + 1);
    localparam logic [WW-1:0] CAP = (WW'(1) << (CW - 1)) - WW'(1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] dvs_reg;
    logic [CW-1:0] rem_reg;
    logic [QW-1:0] q_reg;
    logic [NW-1:0] cnt_reg;

    logic [CW:0]   rem_sh;
    logic          fits;
    logic [WW-1:0] q_ext;
    logic          over;

    // dividend is a single one at the top quotient position
    assign rem_sh = {rem_reg, (cnt_reg == '0)};
    assign fits   = rem_sh >= (CW + 1)'(dvs_reg);
    assign q_ext  = WW'(q_reg);
    assign over   = q_ext > CAP;

    always_comb begin
        stat.done = done_reg;
        stat.sat  = over;
        quotient  = over ? CAP[CW-2:0] : q_ext[CW-2:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == NW'(QW - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? CW'(rem_sh - (CW + 1)'(dvs_reg)) : rem_sh[CW-1:0];
            q_reg   <= {q_reg[QW-2:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

/* sim/matrix_inverse_4x4_checker.sv */
// channel monitor, inverse predictor and result comparison for the 4x4 matrix inverse
module matrix_inverse_4x4_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  mi4_pkg::entry_t           s_data,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  mi4_pkg::result_t          m_data,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int CW   = 48;
    localparam int DW   = mi4_pkg::DATA_WIDTH;

    // transpose indexes of each pair product, upper half first
    localparam int PAIR_L [24] = '{10, 11, 9, 11, 9, 10, 8, 11, 8, 10, 8, 9,
                                   2, 3, 1, 3, 1, 2, 0, 3, 0, 2, 0, 1};
    localparam int PAIR_R [24] = '{15, 14, 15, 13, 14, 13, 15, 12, 14, 12, 13, 12,
                                   7, 6, 7, 5, 6, 5, 7, 4, 6, 4, 5, 4};
    // per cofactor: (pair, transpose entry) x6, first three added, last three subtracted
    localparam int COF_TERM [16][12] = '{
        '{0,5, 3,6, 4,7, 1,5, 2,6, 5,7},
        '{1,4, 6,6, 9,7, 0,4, 7,6, 8,7},
        '{2,4, 7,5, 10,7, 3,4, 6,5, 11,7},
        '{5,4, 8,5, 11,6, 4,4, 9,5, 10,6},
        '{1,1, 2,2, 5,3, 0,1, 3,2, 4,3},
        '{0,0, 7,2, 8,3, 1,0, 6,2, 9,3},
        '{3,0, 6,1, 11,3, 2,0, 7,1, 10,3},
        '{4,0, 9,1, 10,2, 5,0, 8,1, 11,2},
        '{0,13, 3,14, 4,15, 1,13, 2,14, 5,15},
        '{1,12, 6,14, 9,15, 0,12, 7,14, 8,15},
        '{2,12, 7,13, 10,15, 3,12, 6,13, 11,15},
        '{5,12, 8,13, 11,14, 4,12, 9,13, 10,14},
        '{2,10, 5,11, 1,9, 4,11, 0,9, 3,10},
        '{8,11, 0,8, 7,10, 6,10, 9,11, 1,8},
        '{6,9, 11,11, 3,8, 10,11, 2,8, 7,9},
        '{10,10, 4,8, 9,9, 8,9, 11,10, 5,8}
    };

    longint           matrix_entries [16];
    mi4_pkg::result_t inverse_queue [$];

    function automatic longint clamp_to(longint v, int w, inout bit sat);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            sat = 1;
            return hi;
        end
        if (v < lo) begin
            sat = 1;
            return lo;
        end
        return v;
    endfunction

    // exact product, floor shift, clamp to w bits
    function automatic longint fixed_mul(longint a, longint b, int s, int w, inout bit sat);
        logic signed [127:0] pa;
        logic signed [127:0] pb;
        logic signed [127:0] p;
        logic signed [127:0] hi;
        pa = a;
        pb = b;
        p  = (pa * pb) >>> s;
        hi = (128'sd1 <<< (w - 1)) - 128'sd1;
        if (p > hi) begin
            sat = 1;
            return longint'(hi);
        end
        if (p < -hi - 128'sd1) begin
            sat = 1;
            return longint'(-hi - 128'sd1);
        end
        return longint'(p);
    endfunction

    function automatic longint det_reciprocal(longint d, inout bit sat);
        longint unsigned mag;
        longint unsigned cap;
        longint unsigned rem;
        longint unsigned q;
        mag = d < 0 ? longint'(-d) : longint'(d);
        cap = (64'd1 << (CW - 1)) - 1;
        rem = 0;
        q   = 0;
        for (int pos = 3 * FRAC; pos >= 0; pos--) begin
            rem = (rem << 1) | ((pos == 3 * FRAC) ? 64'd1 : 64'd0);
            if (q <= cap) q = q << 1;
            if (rem >= mag) begin
                rem = rem - mag;
                q   = q | 64'd1;
            end
        end
        if (q > cap) begin
            sat = 1;
            q   = cap;
        end
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic void predict_inverse();
        longint           t [16];
        longint           pr [24];
        bit               psat [24];
        longint           cof [16];
        bit               csat [16];
        longint           det;
        longint           recip;
        longint           sum;
        longint           v;
        bit               dsat;
        bit               f;
        int               p;
        mi4_pkg::result_t r;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                t[4 * i + j] = matrix_entries[4 * j + i];
        for (int k = 0; k < 24; k++) begin
            psat[k] = 0;
            pr[k] = fixed_mul(t[PAIR_L[k]], t[PAIR_R[k]], FRAC, CW, psat[k]);
        end
        for (int i = 0; i < 16; i++) begin
            sum = 0;
            f   = 0;
            for (int k = 0; k < 6; k++) begin
                p = COF_TERM[i][2 * k] + (i >= 8 ? 12 : 0);
                v = fixed_mul(pr[p], t[COF_TERM[i][2 * k + 1]], FRAC, CW, f);
                f = f | psat[p];
                sum = k < 3 ? sum + v : sum - v;
            end
            cof[i]  = clamp_to(sum, CW, f);
            csat[i] = f;
        end
        dsat = 0;
        det  = 0;
        for (int k = 0; k < 4; k++) det += fixed_mul(t[k], cof[k], FRAC, CW, dsat);
        det   = clamp_to(det, CW, dsat);
        recip = det == 0 ? 0 : det_reciprocal(det, dsat);
        for (int i = 0; i < 16; i++) begin
            r.result_index = 4'(i);
            r.last_result  = i == 15;
            if (recip == 0) begin
                r.result_value = '0;
                r.singular     = 1;
                r.saturated    = 0;
            end else begin
                f = csat[i] | dsat;
                v = fixed_mul(cof[i], recip, 2 * FRAC, DW, f);
                r.result_value = v[DW-1:0];
                r.singular     = 0;
                r.saturated    = f;
            end
            inverse_queue.push_back(r);
        end
    endfunction

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    assign pending = inverse_queue.size();

    always @(posedge aclk) begin
        mi4_pkg::result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                matrix_entries[s_data.entry_index] = longint'(s_data.entry_value);
                if (s_data.last_entry) predict_inverse();
            end
            if (m_valid && m_ready) begin
                if (inverse_queue.size() == 0) begin
                    report($sformatf("unexpected result transaction index %0d",
                                     m_data.result_index));
                end else begin
                    want = inverse_queue.pop_front();
                    if (m_data.result_index !== want.result_index)
                        report($sformatf("result_index %0d, want %0d",
                                         m_data.result_index, want.result_index));
                    if (m_data.result_value !== want.result_value)
                        report($sformatf("index %0d result_value %h, want %h",
                                         want.result_index, m_data.result_value,
                                         want.result_value));
                    if (m_data.singular !== want.singular)
                        report($sformatf("index %0d singular %b, want %b",
                                         want.result_index, m_data.singular, want.singular));
                    if (m_data.saturated !== want.saturated)
                        report($sformatf("index %0d saturated %b, want %b",
                                         want.result_index, m_data.saturated, want.saturated));
                    if (m_data.last_result !== want.last_result)
                        report($sformatf("index %0d last_result %b, want %b",
                                         want.result_index, m_data.last_result,
                                         want.last_result));
                end
            end
        end
    end

endmodule

/* sim/tb_matrix_inverse_4x4_unit.sv */
// stimulus, flow control and verdict for the 4x4 matrix inverse unit
module tb_matrix_inverse_4x4_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ONE = 32'h0001_0000;

    logic             aclk = 0;
    logic             aresetn = 0;
    logic             s_valid = 0;
    logic             s_ready;
    mi4_pkg::entry_t  s_data = '0;
    logic             m_valid;
    logic             m_ready = 0;
    mi4_pkg::result_t m_data;
    int               fail_count;
    int               pending;
    int               cycles = 0;
    int               entries_sent = 0;

    matrix_inverse_4x4_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    matrix_inverse_4x4_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // one entry transaction, driven at the falling edge
    task automatic send_entry(int idx, logic [31:0] val, bit last);
        if (!(entries_sent >= 40 && entries_sent < 75)) begin
            while ($urandom_range(0, 99) < 32) begin
                s_valid = 0;
                @(negedge aclk);
            end
        end
        s_valid = 1;
        s_data.entry_index = 4'(idx);
        s_data.entry_value = val;
        s_data.last_entry  = last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 0;
        entries_sent++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 8 * ONE) - 4 * ONE;
            6: return $urandom;
            7: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'hffff_ffff;
                endcase
            end
            8: return ($urandom_range(0, 6) - 3) * ONE;
            default: return $urandom_range(0, 64) - 32;
        endcase
    endfunction

    task automatic send_matrix();
        int ord [16];
        int j;
        int tmp;
        for (int i = 0; i < 16; i++) ord[i] = i;
        for (int i = 15; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = ord[i];
            ord[i] = ord[j];
            ord[j] = tmp;
        end
        for (int i = 0; i < 16; i++) send_entry(ord[i], pick_value(), i == 15);
    endtask

    // receiver: random stalls, a stretch with no stalls, and one long hold-off mid-burst
    initial begin
        int taken;
        bit held;
        taken = 0;
        held = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && taken >= 20 && m_valid) begin
                held = 1;
                m_ready = 0;
                repeat (3000) @(negedge aclk);
            end
            m_ready = (cycles >= 4000 && cycles < 8000) || $urandom_range(0, 99) >= 32;
            if (m_valid && m_ready) taken++;
        end
    end

    initial begin
        repeat (11) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);
        // identity, then single rewrites: zero row, extreme entries, tiny determinant
        for (int i = 0; i < 16; i++)
            send_entry(i, (i % 5 == 0) ? ONE : 32'h0, i == 15);
        send_entry(0, 32'h0, 1);
        send_entry(0, ONE, 0);
        send_entry(5, 32'h7fff_ffff, 1);
        send_entry(5, 32'h8000_0000, 1);
        send_entry(5, 32'h0000_0001, 1);
        send_entry(5, 32'hffff_ffff, 1);
        while (entries_sent < 100) begin
            if ($urandom_range(0, 9) < 7) begin
                send_matrix();
            end else begin
                // up to five rewrites that are only stored, then a start on a random entry
                repeat ($urandom_range(0, 5))
                    send_entry($urandom_range(0, 15), pick_value(), 0);
                send_entry($urandom_range(0, 15), pick_value(), 1);
            end
        end
        wait (pending == 0);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
